FILE: rtl/core/broadcast_ack_tracker_defines.svh
// Assertion macros shared by the broadcast ack tracker RTL.
`ifndef BROADCAST_ACK_TRACKER_DEFINES_SVH
`define BROADCAST_ACK_TRACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BAT_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BAT_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/core/bat_pkg.sv
// Shared types, codes and constants of the broadcast ack tracker.
package bat_pkg;

  localparam int MAX_NODES_DEF = 16;

  localparam logic [1:0] OP_RX      = 2'd0;
  localparam logic [1:0] OP_TX      = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;
  localparam logic [1:0] OP_JOIN    = 2'd3;

  localparam logic CFG_OWN_ID      = 1'b0;
  localparam logic CFG_RETRY_LIMIT = 1'b1;

  localparam logic [3:0] OWN_ID_RST      = 4'd1;
  localparam logic [3:0] RETRY_LIMIT_RST = 4'd5;

  localparam logic [7:0] CH_ACK  = 8'h41;
  localparam logic [7:0] CH_Q    = 8'h51;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  node_id;
    logic [55:0] frame_bytes;
    logic        track_ack;
  } bat_item_t;

  typedef struct packed {
    logic [3:0] own_node_id;
    logic [3:0] retry_limit;
  } bat_cfg_t;

  typedef struct packed {
    logic        deliver;
    logic        ack_matched;
    logic        all_acked;
    logic        resend_request;
    logic [15:0] dropped_mask;
    logic [15:0] connected_now;
    logic        acks_pending;
  } bat_result_t;

endpackage

FILE: rtl/core/broadcast_ack_tracker.sv
// Top level of the broadcast ack tracker: input stage, tracker, result register.
//
// Accepts one transaction per clock while the output is not stalled and returns one result
// per transaction, in order. A transaction is held in an input register, the tracker updates
// its node masks, stored frame and retry count as the transaction passes on, and the result
// lands in an output register: out_valid rises once the transaction has passed the input
// register and then the output register. Throughput is one transaction per cycle while the
// output is not stalled; a stalled output holds one result while one more transaction waits
// in the input register. Config writes are always taken (cfg_ready is always high)
// and should be issued only while no transaction is in flight.
`include "broadcast_ack_tracker_defines.svh"

module broadcast_ack_tracker import bat_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [3:0]  in_node_id,
  input  logic [55:0] in_frame_bytes,
  input  logic        in_track_ack,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_deliver,
  output logic        out_ack_matched,
  output logic        out_all_acked,
  output logic        out_resend_request,
  output logic [15:0] out_dropped_mask,
  output logic [15:0] out_connected_now,
  output logic        out_acks_pending,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata
);

  logic        s1_valid_r, s1_valid_nxt;
  bat_item_t   s1_item_r;
  logic        out_valid_r, out_valid_nxt;
  bat_result_t out_res_r;
  bat_result_t step_res;
  bat_cfg_t    cfg;
  logic        advance;
  logic        fire;
  logic        in_take;

  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  bat_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bat_tracker #(
    .MAX_NODES (MAX_NODES)
  ) u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (step_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.opcode      <= in_opcode;
      s1_item_r.node_id     <= in_node_id;
      s1_item_r.frame_bytes <= in_frame_bytes;
      s1_item_r.track_ack   <= in_track_ack;
    end
    if (fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_deliver        = out_res_r.deliver;
  assign out_ack_matched    = out_res_r.ack_matched;
  assign out_all_acked      = out_res_r.all_acked;
  assign out_resend_request = out_res_r.resend_request;
  assign out_dropped_mask   = out_res_r.dropped_mask;
  assign out_connected_now  = out_res_r.connected_now;
  assign out_acks_pending   = out_res_r.acks_pending;

  `BAT_ASSERT_NXT(a_fire_fills_out, fire, out_valid_r, "processed transaction left no result")
  `BAT_ASSERT_NXT(a_stall_holds_s1, s1_valid_r && !advance, s1_valid_r && $stable(s1_item_r), "stalled input stage changed")
  `BAT_ASSERT_IMP(a_no_take_when_full, s1_valid_r && !advance, !in_ready, "input taken while stage full")

endmodule

FILE: rtl/core/bat_cfg_regs.sv
// Configuration registers: own node id and retry limit.
module bat_cfg_regs import bat_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata,
  output bat_cfg_t   cfg
);

  bat_cfg_t cfg_r;
  bat_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_ID:      cfg_nxt.own_node_id = cfg_wdata;
        CFG_RETRY_LIMIT: cfg_nxt.retry_limit = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_node_id <= OWN_ID_RST;
      cfg_r.retry_limit <= RETRY_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/bat_tracker.sv
// Tracker state (node masks, stored frame, retry count) and its per-transaction update.
`include "broadcast_ack_tracker_defines.svh"

module bat_tracker import bat_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  bat_item_t   item,
  input  bat_cfg_t    cfg,
  output bat_result_t result
);

  localparam int OutW = (MAX_NODES < 16) ? MAX_NODES : 16;

  logic [MAX_NODES-1:0] conn_r, conn_nxt;
  logic [MAX_NODES-1:0] pend_r, pend_nxt;
  logic [47:0]          frame_r, frame_nxt;
  logic [3:0]           retry_r, retry_nxt;

  logic [MAX_NODES-1:0] id_bit;
  logic [MAX_NODES-1:0] dropped;
  logic [7:0]           b0, b1, b2;
  logic [7:0]           own_digit;
  logic [3:0]           retry_inc;

  assign b0        = item.frame_bytes[7:0];
  assign b1        = item.frame_bytes[15:8];
  assign b2        = item.frame_bytes[23:16];
  assign own_digit = CH_ZERO + {4'd0, cfg.own_node_id};
  assign retry_inc = retry_r + 4'd1;

  // ids at or past MAX_NODES map to no bit
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      id_bit[i] = (int'(item.node_id) == i);
    end
  end

  always_comb begin
    conn_nxt  = conn_r;
    pend_nxt  = pend_r;
    frame_nxt = frame_r;
    retry_nxt = retry_r;
    dropped   = '0;
    result    = '0;
    case (item.opcode)
      OP_RX: begin
        if (b0 != CH_ACK) begin
          if (b0 == CH_Q || b2 == own_digit || b2 == CH_ZERO) begin
            result.deliver = 1'b1;
            if (b0 == CH_C && b1 == CH_B) begin
              pend_nxt = '0;
            end
          end
        end else begin
          if (item.frame_bytes[55:8] == frame_r && (pend_r & id_bit) != '0) begin
            pend_nxt           = pend_r & ~id_bit;
            result.ack_matched = 1'b1;
          end
          result.all_acked = (pend_r != '0) && (pend_nxt == '0);
        end
      end
      OP_TX: begin
        if (item.track_ack) begin
          pend_nxt  = conn_r;
          frame_nxt = item.frame_bytes[47:0];
          retry_nxt = '0;
        end
      end
      OP_TIMEOUT: begin
        retry_nxt = retry_inc;
        if (retry_inc == cfg.retry_limit) begin
          retry_nxt = '0;
          dropped   = pend_r & conn_r;
          conn_nxt  = conn_r & ~pend_r;
          pend_nxt  = conn_r & ~pend_r;
        end
        result.resend_request = 1'b1;
      end
      OP_JOIN: begin
        conn_nxt = conn_r | id_bit;
      end
      default: begin
        conn_nxt = conn_r;
      end
    endcase
    result.dropped_mask  = 16'(dropped[OutW-1:0]);
    result.connected_now = 16'(conn_nxt[OutW-1:0]);
    result.acks_pending  = (pend_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_r  <= '0;
      pend_r  <= '0;
      frame_r <= '0;
      retry_r <= '0;
    end else if (fire) begin
      conn_r  <= conn_nxt;
      pend_r  <= pend_nxt;
      frame_r <= frame_nxt;
      retry_r <= retry_nxt;
    end
  end

  `BAT_ASSERT_IMP(a_pend_in_conn, 1'b1, (pend_r & ~conn_r) == '0, "pending node not connected")
  `BAT_ASSERT_IMP(a_all_needs_match, fire && result.all_acked, result.ack_matched, "all_acked without a matched ack")
  `BAT_ASSERT_IMP(a_drop_on_timeout, fire && result.dropped_mask != '0, result.resend_request, "nodes dropped outside a timeout")
  `BAT_ASSERT_NXT(a_tx_arms, fire && item.opcode == OP_TX && item.track_ack, pend_r == $past(conn_r), "tracked send did not arm pending mask")

endmodule

FILE: tb/tb_broadcast_ack_tracker.sv
// Testbench for broadcast_ack_tracker: directed and random bus events checked by a scoreboard.
`timescale 1ns / 1ps

module tb_broadcast_ack_tracker import bat_pkg::*;;

  localparam int ITEMS_PER_PHASE = 176;
  localparam int HOLD_CYCLES     = 80;
  localparam int QUIET_LIMIT     = 2000;
  localparam logic [47:0] TRK_FRAME = 48'hFF00_A55A_0FF0;

  // Tracks node masks and predicts one result per accepted transaction.
  class ack_scoreboard;
    bat_result_t expected_q[$];
    int          errors;
    logic [15:0] connected;
    logic [15:0] pending;
    logic [47:0] tracked_frame;
    logic [3:0]  retries;
    logic [3:0]  own_id;
    logic [3:0]  retry_lim;

    function new();
      errors        = 0;
      connected     = '0;
      pending       = '0;
      tracked_frame = '0;
      retries       = '0;
      own_id        = OWN_ID_RST;
      retry_lim     = RETRY_LIMIT_RST;
    endfunction

    function void write_reg(logic idx, logic [3:0] val);
      if (idx == CFG_OWN_ID) begin
        own_id = val;
      end else begin
        retry_lim = val;
      end
    endfunction

    function void note_input(bat_item_t it);
      bat_result_t r;
      logic [15:0] bit_of;
      logic [7:0]  b0, b1, b2;
      logic        had_pending;
      r      = '0;
      bit_of = 16'(1) << it.node_id;
      b0     = it.frame_bytes[7:0];
      b1     = it.frame_bytes[15:8];
      b2     = it.frame_bytes[23:16];
      case (it.opcode)
        OP_RX: begin
          if (b0 != CH_ACK) begin
            if (b0 == CH_Q || b2 == CH_ZERO + 8'(own_id) || b2 == CH_ZERO) begin
              r.deliver = 1'b1;
              if (b0 == CH_C && b1 == CH_B) pending = '0;
            end
          end else begin
            had_pending = |pending;
            // ack carries the tracked frame shifted up by one byte
            if (it.frame_bytes[55:8] == tracked_frame && (pending & bit_of) != '0) begin
              pending       &= ~bit_of;
              r.ack_matched  = 1'b1;
            end
            r.all_acked = had_pending && pending == '0;
          end
        end
        OP_TX: begin
          if (it.track_ack) begin
            pending       = connected;
            tracked_frame = it.frame_bytes[47:0];
            retries       = '0;
          end
        end
        OP_TIMEOUT: begin
          retries = retries + 4'd1;
          if (retries == retry_lim) begin
            retries        = '0;
            r.dropped_mask = pending & connected;
            connected     &= ~pending;
            pending        = connected;
          end
          r.resend_request = 1'b1;
        end
        OP_JOIN: begin
          connected |= bit_of;
        end
        default: ;
      endcase
      r.connected_now = connected;
      r.acks_pending  = |pending;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(bat_result_t got);
      bat_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %0h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("deliver", 16'(want.deliver), 16'(got.deliver));
      compare_field("ack_matched", 16'(want.ack_matched), 16'(got.ack_matched));
      compare_field("all_acked", 16'(want.all_acked), 16'(got.all_acked));
      compare_field("resend_request", 16'(want.resend_request), 16'(got.resend_request));
      compare_field("dropped_mask", want.dropped_mask, got.dropped_mask);
      compare_field("connected_now", want.connected_now, got.connected_now);
      compare_field("acks_pending", 16'(want.acks_pending), 16'(got.acks_pending));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [3:0]  in_node_id = '0;
  logic [55:0] in_frame_bytes = '0;
  logic        in_track_ack = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_deliver;
  logic        out_ack_matched;
  logic        out_all_acked;
  logic        out_resend_request;
  logic [15:0] out_dropped_mask;
  logic [15:0] out_connected_now;
  logic        out_acks_pending;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [3:0]  cfg_wdata = '0;

  ack_scoreboard sb = new();
  int unsigned   tx_idle_pct  = 0;
  int unsigned   rx_stall_pct = 0;
  int unsigned   hold_reqs    = 0;
  int unsigned   quiet_cycles = 0;

  int unsigned tx_idle_tab[4]  = '{0, 45, 0, 6};
  int unsigned rx_stall_tab[4] = '{0, 0, 45, 6};
  logic [3:0]  own_id_tab[4]   = '{4'd1, 4'd15, 4'd0, 4'd7};
  logic [3:0]  limit_tab[4]    = '{4'd5, 4'd15, 4'd1, 4'd0};

  broadcast_ack_tracker u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_node_id        (in_node_id),
    .in_frame_bytes    (in_frame_bytes),
    .in_track_ack      (in_track_ack),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_deliver       (out_deliver),
    .out_ack_matched   (out_ack_matched),
    .out_all_acked     (out_all_acked),
    .out_resend_request(out_resend_request),
    .out_dropped_mask  (out_dropped_mask),
    .out_connected_now (out_connected_now),
    .out_acks_pending  (out_acks_pending),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int unsigned holds_taken;
    int unsigned hold_left;
    holds_taken = 0;
    hold_left   = 0;
    forever begin
      @(negedge clk);
      if (holds_taken != hold_reqs) begin
        holds_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    bat_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.deliver        = out_deliver;
      got.ack_matched    = out_ack_matched;
      got.all_acked      = out_all_acked;
      got.resend_request = out_resend_request;
      got.dropped_mask   = out_dropped_mask;
      got.connected_now  = out_connected_now;
      got.acks_pending   = out_acks_pending;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bat_item_t mk(logic [1:0] op, logic [3:0] id, logic [55:0] fr, logic tr);
    bat_item_t it;
    it.opcode      = op;
    it.node_id     = id;
    it.frame_bytes = fr;
    it.track_ack   = tr;
    return it;
  endfunction

  function automatic logic [55:0] rand_frame();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[55:0];
  endfunction

  // Mostly joins, tracked sends, acks of the tracked frame and timeouts; some noise.
  function automatic bat_item_t gen_event();
    bat_item_t   it;
    int unsigned pick;
    it   = mk(2'($urandom_range(3)), 4'($urandom_range(15)), rand_frame(), 1'($urandom_range(1)));
    pick = $urandom_range(99);
    if (pick < 14) begin
      it.opcode = OP_JOIN;
    end else if (pick < 28) begin
      it.opcode    = OP_TX;
      it.track_ack = (pick < 24);
    end else if (pick < 58) begin
      it.opcode      = OP_RX;
      it.frame_bytes = {sb.tracked_frame, CH_ACK};
      if (sb.pending != '0 && $urandom_range(3) != 0) begin
        while (!sb.pending[it.node_id]) it.node_id = 4'($urandom_range(15));
      end
    end else if (pick < 63) begin
      it.opcode           = OP_RX;
      it.frame_bytes[7:0] = CH_ACK;
    end else if (pick < 80) begin
      it.opcode = OP_RX;
      case ($urandom_range(2))
        0: it.frame_bytes[7:0] = CH_Q;
        1: it.frame_bytes[15:0] = {CH_B, CH_C};
        default: ;
      endcase
      case ($urandom_range(2))
        0: it.frame_bytes[23:16] = CH_ZERO + 8'(sb.own_id);
        1: it.frame_bytes[23:16] = CH_ZERO;
        default: ;
      endcase
    end else if (pick < 95) begin
      it.opcode = OP_TIMEOUT;
    end
    return it;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_item(bat_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= it.opcode;
    in_node_id     <= it.node_id;
    in_frame_bytes <= it.frame_bytes;
    in_track_ack   <= it.track_ack;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(logic [3:0] own, logic [3:0] lim);
    wait_all_results();
    repeat (3) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_OWN_ID;
    cfg_wdata <= own;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_OWN_ID, own);
    @(negedge clk);
    cfg_index <= CFG_RETRY_LIMIT;
    cfg_wdata <= lim;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_RETRY_LIMIT, lim);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bat_item_t directed[$];
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    write_cfg(4'd3, 4'd2);
    directed = '{
      mk(OP_RX, 4'd0, {48'h0, CH_ACK}, 1'b0),                   // ack, nothing pending
      mk(OP_TIMEOUT, 4'd9, 56'h0, 1'b0),                        // timeout, nothing pending
      mk(OP_JOIN, 4'd0, 56'h0, 1'b0),
      mk(OP_JOIN, 4'd15, 56'h0, 1'b0),
      mk(OP_JOIN, 4'd5, 56'h0, 1'b0),
      mk(OP_JOIN, 4'd5, 56'h0, 1'b0),                           // already connected
      mk(OP_TX, 4'd0, {8'hEE, TRK_FRAME}, 1'b0),                // untracked send
      mk(OP_TX, 4'd0, {8'hEE, TRK_FRAME}, 1'b1),
      mk(OP_RX, 4'd5, {TRK_FRAME, CH_ACK}, 1'b0),
      mk(OP_RX, 4'd5, {TRK_FRAME, CH_ACK}, 1'b0),               // sender no longer pending
      mk(OP_RX, 4'd3, {TRK_FRAME, CH_ACK}, 1'b0),               // sender not connected
      mk(OP_RX, 4'd0, {TRK_FRAME ^ 48'h1, CH_ACK}, 1'b0),       // stale frame bytes
      mk(OP_TIMEOUT, 4'd0, 56'h0, 1'b0),
      mk(OP_TIMEOUT, 4'd0, 56'h0, 1'b0),                        // drop silent nodes
      mk(OP_RX, 4'd5, {TRK_FRAME, CH_ACK}, 1'b0),               // empties pending
      mk(OP_RX, 4'd2, {32'h0, 8'h77, 8'h00, CH_Q}, 1'b0),
      mk(OP_RX, 4'd2, {32'h0, 8'h33, 8'h00, 8'h5A}, 1'b0),      // addressed to own id
      mk(OP_RX, 4'd2, {32'h0, CH_ZERO, 8'h00, 8'h5A}, 1'b0),    // addressed to all
      mk(OP_RX, 4'd2, {32'h0, 8'h39, 8'h00, 8'h5A}, 1'b0),      // someone else's
      mk(OP_TX, 4'd0, {8'h11, TRK_FRAME}, 1'b1),
      mk(OP_RX, 4'd1, {32'h0, CH_ZERO, CH_B, CH_C}, 1'b0),      // CB clears pending
      mk(OP_RX, 4'd1, {32'h0, 8'h37, CH_B, CH_C}, 1'b0),
      mk(OP_RX, 4'd0, 56'h0, 1'b0),
      mk(OP_JOIN, 4'd15, {56{1'b1}}, 1'b1),
      mk(OP_RX, 4'd15, {56{1'b1}}, 1'b1)
    };
    foreach (directed[i]) send_item(directed[i]);

    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(own_id_tab[ph], limit_tab[ph]);
      tx_idle_pct  = tx_idle_tab[ph];
      rx_stall_pct = rx_stall_tab[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == 60) hold_reqs++;
        if (ph == 2 && n == 100) wait_all_results();
        if (n == 120) begin
          // long resend run, long enough to wrap the retry count
          send_item(mk(OP_TX, 4'($urandom_range(15)), rand_frame(), 1'b1));
          repeat (17) begin
            send_item(mk(OP_TIMEOUT, 4'($urandom_range(15)), rand_frame(),
                         1'($urandom_range(1))));
          end
        end
        send_item(gen_event());
      end
    end

    wait_all_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bat_pkg.sv
rtl/core/bat_cfg_regs.sv
rtl/core/bat_tracker.sv
rtl/core/broadcast_ack_tracker.sv
tb/tb_broadcast_ack_tracker.sv
